// File: rtl/qpc_pkg.sv
// shared constants and a popcount helper for the quad pixel coverage block
`default_nettype none

package qpc_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int PIXEL_BITS_DEF = 12;

    localparam int N_CORNERS  = 4;
    localparam int GRID       = 3;
    localparam int N_SAMPLES  = GRID * GRID;
    localparam int COUNT_W    = 4;
    localparam int OUT_DATA_W = 16;

    function automatic logic [COUNT_W-1:0] f_popcount(input logic [N_SAMPLES-1:0] bits);
        logic [COUNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < N_SAMPLES; i++) begin
            sum = sum + {{(COUNT_W-1){1'b0}}, bits[i]};
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

// File: rtl/quad_pixel_coverage_3x3.sv
// 3x3 supersampled winding-number coverage of one pixel by a quadrilateral
//
//  channel | dir | handshake                     | tdata (lowest bit up)
//  --------+-----+-------------------------------+------------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | pixel_x, pixel_y, corner_a_x .. corner_d_y
//  m_axis  | out | m_axis_tvalid / m_axis_tready | coverage_count, sample_mask
//
// six register stages: scale by three, products, edge terms, per-sample partial sums,
// cross-product signs, winding sum and count. one item per cycle unless back-pressure on m_axis fills every stage.
// each stage has its own valid bit and loads when it is empty or its successor loads,
// so bubbles close up and an item is still taken while a result waits in the output register if a stage is empty.
// synchronous reset clears the valid bits only.
`default_nettype none

module quad_pixel_coverage_3x3 #(
    parameter int FRAC_BITS  = qpc_pkg::FRAC_BITS_DEF,
    parameter int PIXEL_BITS = qpc_pkg::PIXEL_BITS_DEF,
    parameter int CW         = PIXEL_BITS + FRAC_BITS + 1,
    parameter int IN_W       = ((2 * PIXEL_BITS + 2 * qpc_pkg::N_CORNERS * CW + 7) / 8) * 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pixel_x, pixel_y, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
    // corner_c_x, corner_c_y, corner_d_x, corner_d_y, zero pad
    input  wire logic [IN_W-1:0]                  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // coverage_count, sample_mask, zero pad
    output logic [qpc_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

    localparam int NC      = qpc_pkg::N_CORNERS;
    localparam int G       = qpc_pkg::GRID;
    localparam int NS      = qpc_pkg::N_SAMPLES;
    localparam int CNT_W   = qpc_pkg::COUNT_W;
    localparam int OUT_PAD = qpc_pkg::OUT_DATA_W - CNT_W - NS;
    localparam int QW      = CW + 2;                // corner or sample coordinate at scale three
    localparam int DW      = QW + 1;                // edge delta
    localparam int BW      = PIXEL_BITS + 2;        // three times the pixel index
    localparam int MW      = DW + BW + 1;           // delta times base coordinate
    localparam int XW      = 2 * DW;                // full cross product
    localparam int OFF_C   = 2 * PIXEL_BITS;
    localparam int NSTG    = 6;

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // stage 1: corners and pixel base at scale three
    logic signed [QW-1:0] n_s1_qx [NC];
    logic signed [QW-1:0] n_s1_qy [NC];
    logic        [BW-1:0] n_s1_x0;
    logic        [BW-1:0] n_s1_y0;
    logic signed [QW-1:0] r_s1_qx [NC];
    logic signed [QW-1:0] r_s1_qy [NC];
    logic        [BW-1:0] r_s1_x0;
    logic        [BW-1:0] r_s1_y0;

    always_comb begin
        logic [CW-1:0]        cx;
        logic [CW-1:0]        cy;
        logic signed [QW-1:0] ex;
        logic signed [QW-1:0] ey;
        logic [PIXEL_BITS-1:0] px;
        logic [PIXEL_BITS-1:0] py;
        for (int k = 0; k < NC; k++) begin
            cx = s_axis_tdata[OFF_C + 2 * k * CW +: CW];
            cy = s_axis_tdata[OFF_C + (2 * k + 1) * CW +: CW];
            ex = {{2{cx[CW-1]}}, cx};
            ey = {{2{cy[CW-1]}}, cy};
            n_s1_qx[k] = (ex <<< 1) + ex;
            n_s1_qy[k] = (ey <<< 1) + ey;
        end
        px = s_axis_tdata[PIXEL_BITS-1:0];
        py = s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
        n_s1_x0 = {2'b00, px} + {1'b0, px, 1'b0};
        n_s1_y0 = {2'b00, py} + {1'b0, py, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_qx <= n_s1_qx;
            r_s1_qy <= n_s1_qy;
            r_s1_x0 <= n_s1_x0;
            r_s1_y0 <= n_s1_y0;
        end
    end

    // stage 2: edge deltas, four products per edge, crossing flags per row
    logic signed [DW-1:0]   n_s2_dx  [NC];
    logic signed [DW-1:0]   n_s2_dy  [NC];
    logic signed [2*QW-1:0] n_s2_pse [NC];
    logic signed [2*QW-1:0] n_s2_pes [NC];
    logic signed [MW-1:0]   n_s2_pdy [NC];
    logic signed [MW-1:0]   n_s2_pdx [NC];
    logic        [G-1:0]    n_s2_up  [NC];
    logic        [G-1:0]    n_s2_dn  [NC];
    logic signed [DW-1:0]   r_s2_dx  [NC];
    logic signed [DW-1:0]   r_s2_dy  [NC];
    logic signed [2*QW-1:0] r_s2_pse [NC];
    logic signed [2*QW-1:0] r_s2_pes [NC];
    logic signed [MW-1:0]   r_s2_pdy [NC];
    logic signed [MW-1:0]   r_s2_pdx [NC];
    logic        [G-1:0]    r_s2_up  [NC];
    logic        [G-1:0]    r_s2_dn  [NC];

    always_comb begin
        logic signed [QW-1:0] base_y;
        logic signed [QW-1:0] sy;
        int                   n;
        base_y = $signed({{(QW-BW){1'b0}}, r_s1_y0});
        for (int k = 0; k < NC; k++) begin
            n = (k + 1) % NC;
            n_s2_dx[k]  = {r_s1_qx[n][QW-1], r_s1_qx[n]} - {r_s1_qx[k][QW-1], r_s1_qx[k]};
            n_s2_dy[k]  = {r_s1_qy[n][QW-1], r_s1_qy[n]} - {r_s1_qy[k][QW-1], r_s1_qy[k]};
            n_s2_pse[k] = r_s1_qx[k] * r_s1_qy[n];
            n_s2_pes[k] = r_s1_qy[k] * r_s1_qx[n];
            n_s2_pdy[k] = n_s2_dx[k] * $signed({1'b0, r_s1_y0});
            n_s2_pdx[k] = n_s2_dy[k] * $signed({1'b0, r_s1_x0});
            for (int r = 0; r < G; r++) begin
                sy = (base_y + QW'(r - 1)) <<< FRAC_BITS;
                n_s2_up[k][r] = (r_s1_qy[k] <= sy) && (r_s1_qy[n] > sy);
                n_s2_dn[k][r] = (r_s1_qy[k] > sy) && (r_s1_qy[n] <= sy);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s2_dx  <= n_s2_dx;
            r_s2_dy  <= n_s2_dy;
            r_s2_pse <= n_s2_pse;
            r_s2_pes <= n_s2_pes;
            r_s2_pdy <= n_s2_pdy;
            r_s2_pdx <= n_s2_pdx;
            r_s2_up  <= n_s2_up;
            r_s2_dn  <= n_s2_dn;
        end
    end

    // stage 3: edge constant term and pixel-base term
    logic signed [XW-1:0] n_s3_ce [NC];
    logic signed [XW-1:0] n_s3_t  [NC];
    logic signed [XW-1:0] r_s3_ce [NC];
    logic signed [XW-1:0] r_s3_t  [NC];
    logic signed [DW-1:0] r_s3_dx [NC];
    logic signed [DW-1:0] r_s3_dy [NC];
    logic        [G-1:0]  r_s3_up [NC];
    logic        [G-1:0]  r_s3_dn [NC];

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            n_s3_ce[k] = {{(XW-2*QW){r_s2_pse[k][2*QW-1]}}, r_s2_pse[k]}
                       - {{(XW-2*QW){r_s2_pes[k][2*QW-1]}}, r_s2_pes[k]};
            n_s3_t[k]  = {{(XW-MW){r_s2_pdy[k][MW-1]}}, r_s2_pdy[k]}
                       - {{(XW-MW){r_s2_pdx[k][MW-1]}}, r_s2_pdx[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s3_ce <= n_s3_ce;
            r_s3_t  <= n_s3_t;
            r_s3_dx <= r_s2_dx;
            r_s3_dy <= r_s2_dy;
            r_s3_up <= r_s2_up;
            r_s3_dn <= r_s2_dn;
        end
    end

    // stage 4: per-sample offset terms, before the fraction shift
    logic signed [XW-1:0] n_s4_trc [NC][G][G];
    logic signed [XW-1:0] r_s4_trc [NC][G][G];
    logic signed [XW-1:0] r_s4_ce  [NC];
    logic        [G-1:0]  r_s4_up  [NC];
    logic        [G-1:0]  r_s4_dn  [NC];

    always_comb begin
        logic signed [XW-1:0] dxe;
        logic signed [XW-1:0] dye;
        logic signed [XW-1:0] v;
        for (int k = 0; k < NC; k++) begin
            dxe = {{(XW-DW){r_s3_dx[k][DW-1]}}, r_s3_dx[k]};
            dye = {{(XW-DW){r_s3_dy[k][DW-1]}}, r_s3_dy[k]};
            for (int r = 0; r < G; r++) begin
                for (int c = 0; c < G; c++) begin
                    v = r_s3_t[k];
                    if (r == 0) begin
                        v = v - dxe;
                    end else if (r == G - 1) begin
                        v = v + dxe;
                    end
                    if (c == 0) begin
                        v = v + dye;
                    end else if (c == G - 1) begin
                        v = v - dye;
                    end
                    n_s4_trc[k][r][c] = v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s4_trc <= n_s4_trc;
            r_s4_ce  <= r_s3_ce;
            r_s4_up  <= r_s3_up;
            r_s4_dn  <= r_s3_dn;
        end
    end

    // stage 5: cross-product sign against each crossing edge
    logic [NS-1:0] n_s5_pos [NC];
    logic [NS-1:0] n_s5_neg [NC];
    logic [NS-1:0] r_s5_pos [NC];
    logic [NS-1:0] r_s5_neg [NC];

    always_comb begin
        logic signed [XW-1:0] xprod;
        for (int k = 0; k < NC; k++) begin
            for (int r = 0; r < G; r++) begin
                for (int c = 0; c < G; c++) begin
                    xprod = r_s4_ce[k] + (r_s4_trc[k][r][c] <<< FRAC_BITS);
                    n_s5_pos[k][r*G+c] = r_s4_up[k][r] && (xprod > 0);
                    n_s5_neg[k][r*G+c] = r_s4_dn[k][r] && (xprod < 0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s5_pos <= n_s5_pos;
            r_s5_neg <= n_s5_neg;
        end
    end

    // stage 6: winding number per sample, mask and count
    logic [NS-1:0]    n_s6_mask;
    logic [CNT_W-1:0] n_s6_count;
    logic [NS-1:0]    r_s6_mask;
    logic [CNT_W-1:0] r_s6_count;

    always_comb begin
        logic signed [3:0] wn;
        for (int s = 0; s < NS; s++) begin
            wn = '0;
            for (int k = 0; k < NC; k++) begin
                wn = wn + $signed({3'b000, r_s5_pos[k][s]}) - $signed({3'b000, r_s5_neg[k][s]});
            end
            n_s6_mask[s] = (wn != 0);
        end
        n_s6_count = qpc_pkg::f_popcount(n_s6_mask);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s6_mask  <= n_s6_mask;
            r_s6_count <= n_s6_count;
        end
    end

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, r_s6_mask, r_s6_count};

    // checks
    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_s6_count == CNT_W'($countones(r_s6_mask))))
        else $error("coverage count disagrees with sample mask");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input stalled while a pipeline stage is empty");

    a_accept_enters_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted item missing from first stage");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// File: verif/quad_pixel_coverage_3x3_tb.sv
// self-checking testbench for the 3x3 quad pixel coverage block
module quad_pixel_coverage_3x3_tb;

    localparam int N_CORNERS  = qpc_pkg::N_CORNERS;
    localparam int GRID       = qpc_pkg::GRID;
    localparam int N_SAMPLES  = qpc_pkg::N_SAMPLES;
    localparam int COUNT_W    = qpc_pkg::COUNT_W;
    localparam int OUT_DATA_W = qpc_pkg::OUT_DATA_W;

    localparam int FRAC = qpc_pkg::FRAC_BITS_DEF;
    localparam int PIXW = qpc_pkg::PIXEL_BITS_DEF;
    localparam int CW   = PIXW + FRAC + 1;
    localparam int IN_W = ((2 * PIXW + 2 * N_CORNERS * CW + 7) / 8) * 8;
    localparam int ONE  = 1 << FRAC;
    localparam int CMAX = (1 << (CW - 1)) - 1;
    localparam int CMIN = -(1 << (CW - 1));

    localparam int N_DIR       = 20;
    localparam int N_RAND      = 400;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN       = 16;
    localparam int LIMIT_TIME  = 2000000;

    // packed so that px lands in the lowest bits of tdata
    typedef struct packed {
        logic signed [CW-1:0] dy, dx, cy, cx, by, bx, ay, ax;
        logic [PIXW-1:0]      py, px;
    } t_pix_quad;

    typedef struct packed {
        logic [N_SAMPLES-1:0] mask;
        logic [COUNT_W-1:0]   count;
    } t_cover;

    typedef struct packed {
        bit        typed;
        t_cover    want;
        t_pix_quad q;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // pixel_x, pixel_y, corner_a_x, corner_a_y, .. corner_d_x, corner_d_y
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // coverage_count, sample_mask, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_cover   cover_q[$];
    t_cover   offer_want;
    t_dir_row dir_rows[N_DIR];
    int       errors = 0;
    int       results = 0;
    int       sent_cnt = 0;
    int       in_stalls = 0;
    bit       calm = 1'b0;
    bit       hold_done = 1'b0;

    quad_pixel_coverage_3x3 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("CHECKS FAILED");
        $finish;
    end

    // winding-number coverage at three times the fixed-point scale
    function automatic t_cover predict_cover(t_pix_quad q);
        longint qx[N_CORNERS];
        longint qy[N_CORNERS];
        longint sx, sy, cr;
        int     wn, nx;
        t_cover r;
        qx[0] = $signed(q.ax); qy[0] = $signed(q.ay);
        qx[1] = $signed(q.bx); qy[1] = $signed(q.by);
        qx[2] = $signed(q.cx); qy[2] = $signed(q.cy);
        qx[3] = $signed(q.dx); qy[3] = $signed(q.dy);
        for (int k = 0; k < N_CORNERS; k++) begin
            qx[k] = qx[k] * 3;
            qy[k] = qy[k] * 3;
        end
        r = '0;
        for (int row = 0; row < GRID; row++) begin
            sy = q.py;
            sy = (sy * 3 + row - 1) * ONE;
            for (int col = 0; col < GRID; col++) begin
                sx = q.px;
                sx = (sx * 3 + col - 1) * ONE;
                wn = 0;
                for (int k = 0; k < N_CORNERS; k++) begin
                    nx = (k + 1) % N_CORNERS;
                    cr = (qx[nx] - qx[k]) * (sy - qy[k]) - (sx - qx[k]) * (qy[nx] - qy[k]);
                    if (qy[k] <= sy) begin
                        if (qy[nx] > sy && cr > 0) wn++;
                    end else if (qy[nx] <= sy && cr < 0) begin
                        wn--;
                    end
                end
                if (wn != 0) begin
                    r.mask[row * GRID + col] = 1'b1;
                    r.count = r.count + 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic t_pix_quad quad(int px, int py, int ax, int ay, int bx, int by,
                                       int cx, int cy, int dx, int dy);
        t_pix_quad q;
        q.px = PIXW'(px); q.py = PIXW'(py);
        q.ax = CW'(ax); q.ay = CW'(ay); q.bx = CW'(bx); q.by = CW'(by);
        q.cx = CW'(cx); q.cy = CW'(cy); q.dx = CW'(dx); q.dy = CW'(dy);
        return q;
    endfunction

    function automatic int near_corner(int p, int span);
        int off, v;
        off = $urandom_range(0, 2 * span);
        v = p * ONE + off - span;
        if (v > CMAX) v = CMAX;
        if (v < CMIN) v = CMIN;
        return v;
    endfunction

    function automatic int pick_pixel();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return (1 << PIXW) - 1;
        return $urandom_range(0, (1 << PIXW) - 1);
    endfunction

    // mostly corners within a few pixels so coverage is partial, some anywhere
    function automatic t_pix_quad random_quad();
        t_pix_quad q;
        int px, py, span, m;
        px = pick_pixel();
        py = pick_pixel();
        m = $urandom_range(0, 99);
        if (m >= 85) begin
            q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            q.px = PIXW'(px); q.py = PIXW'(py);
            return q;
        end
        span = (m < 60) ? 3 * ONE : (ONE * 5) / 8;
        return quad(px, py, near_corner(px, span), near_corner(py, span),
                    near_corner(px, span), near_corner(py, span),
                    near_corner(px, span), near_corner(py, span),
                    near_corner(px, span), near_corner(py, span));
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, plus one long hold-off so the pipeline backs up
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent_cnt >= N_DIR + 40) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_cover got, want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) cover_q.push_back(offer_want);
            if (s_axis_tvalid && !s_axis_tready) in_stalls++;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[N_SAMPLES+COUNT_W-1:0];
                if (cover_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing pending, got %h", $time, m_axis_tdata);
                end else begin
                    want = cover_q.pop_front();
                    results++;
                    if (got.count !== want.count) begin
                        errors++;
                        $display("%0t: coverage_count expected %0d got %0d",
                                 $time, want.count, got.count);
                    end
                    if (got.mask !== want.mask) begin
                        errors++;
                        $display("%0t: sample_mask expected %03h got %03h",
                                 $time, want.mask, got.mask);
                    end
                    if (m_axis_tdata[OUT_DATA_W-1:N_SAMPLES+COUNT_W] !== '0) begin
                        errors++;
                        $display("%0t: pad bits expected 0 got %h", $time,
                                 m_axis_tdata[OUT_DATA_W-1:N_SAMPLES+COUNT_W]);
                    end
                end
            end
        end
    end

    initial begin : tx_side
        t_pix_quad q;
        int        gap;

        // typed rows: point, full-range squares, flat, far away, tiny center square
        dir_rows[0]  = {1'b1, 9'h000, 4'd0, quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
        dir_rows[1]  = {1'b1, 9'h1FF, 4'd9,
                        quad(0, 0, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX)};
        dir_rows[2]  = {1'b1, 9'h1FF, 4'd9,
                        quad(4095, 4095, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX)};
        dir_rows[3]  = {1'b1, 9'h1FF, 4'd9,
                        quad(4095, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN)};
        dir_rows[4]  = {1'b1, 9'h000, 4'd0,
                        quad(4095, 4095, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX)};
        dir_rows[5]  = {1'b1, 9'h000, 4'd0,
                        quad(0, 0, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN)};
        dir_rows[6]  = {1'b1, 9'h000, 4'd0, quad(0, 0, 100 * ONE, 100 * ONE, 110 * ONE,
                        100 * ONE, 110 * ONE, 110 * ONE, 100 * ONE, 110 * ONE)};
        dir_rows[7]  = {1'b1, 9'h010, 4'd1, quad(10, 10, 10 * ONE - 26, 10 * ONE - 26,
                        10 * ONE + 26, 10 * ONE - 26, 10 * ONE + 26, 10 * ONE + 26,
                        10 * ONE - 26, 10 * ONE + 26)};
        // samples sitting exactly on edges and corners
        dir_rows[8]  = {1'b0, 13'd0, quad(10, 10, 10 * ONE, 10 * ONE, 20 * ONE, 10 * ONE,
                        20 * ONE, 20 * ONE, 10 * ONE, 20 * ONE)};
        dir_rows[9]  = {1'b0, 13'd0, quad(10, 10, 10 * ONE, 0, 4000 * ONE, 0,
                        4000 * ONE, 4000 * ONE, 10 * ONE, 4000 * ONE)};
        dir_rows[10] = {1'b0, 13'd0, quad(10, 10, 5 * ONE, 10 * ONE, 15 * ONE, 10 * ONE,
                        15 * ONE, 15 * ONE, 5 * ONE, 15 * ONE)};
        // repeated corner, collinear, bowtie, dart with a corner on the center
        dir_rows[11] = {1'b0, 13'd0, quad(10, 10, 9 * ONE, 9 * ONE, 12 * ONE, 9 * ONE,
                        9 * ONE, 12 * ONE, 9 * ONE, 12 * ONE)};
        dir_rows[12] = {1'b0, 13'd0, quad(10, 10, 8 * ONE, 8 * ONE, 10 * ONE, 10 * ONE,
                        12 * ONE, 12 * ONE, 14 * ONE, 14 * ONE)};
        dir_rows[13] = {1'b0, 13'd0, quad(10, 10, 8 * ONE, 8 * ONE, 12 * ONE, 12 * ONE,
                        12 * ONE, 8 * ONE, 8 * ONE, 12 * ONE)};
        dir_rows[14] = {1'b0, 13'd0, quad(10, 10, 8 * ONE, 8 * ONE, 12 * ONE, 10 * ONE,
                        8 * ONE, 12 * ONE, 10 * ONE, 10 * ONE)};
        dir_rows[15] = {1'b0, 13'd0, quad(10, 10, 9 * ONE, 11 * ONE, 11 * ONE, 9 * ONE,
                        12 * ONE, 12 * ONE, 12 * ONE, 12 * ONE)};
        // partial coverage at the corners of the pixel range
        dir_rows[16] = {1'b0, 13'd0, quad(4095, 0, 4094 * ONE, -ONE, CMAX, -ONE,
                        CMAX, ONE / 2, 4094 * ONE + 128, ONE / 2)};
        dir_rows[17] = {1'b0, 13'd0, quad(0, 4095, CMIN, 4095 * ONE, 0, 4095 * ONE - 100,
                        100, CMAX, CMIN, CMAX)};
        // alternating bit patterns
        dir_rows[18] = {1'b0, 13'd0, quad('hAAA, 'h555, 'h0AAAAA, 'h155555, 'h0AAAAA,
                        'h0AAAAA, 'h155555, 'h155555, 'h155555, 'h0AAAAA)};
        dir_rows[19] = {1'b0, 13'd0, quad('h555, 'hAAA, 'h155555, 'h0AAAAA, 'h155555,
                        'h155555, 'h0AAAAA, 'h0AAAAA, 'h0AAAAA, 'h155555)};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_DIR + N_RAND; n++) begin
            calm = (n >= N_DIR + 120 && n < N_DIR + 180);
            if (n < N_DIR) begin
                q = dir_rows[n].q;
                offer_want = dir_rows[n].typed ? dir_rows[n].want : predict_cover(q);
            end else begin
                q = random_quad();
                offer_want = predict_cover(q);
            end
            gap = (calm || $urandom_range(0, 9) < 6) ? 0 : idle_len();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= q;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            sent_cnt++;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b0;

        while (cover_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("covered %0d pixel items (%0d directed: full-range squares, edge hits,",
                 sent_cnt, N_DIR);
        $display("  flat, bowtie and dart quads), %0d results, %0d input stall cycles",
                 results, in_stalls);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: quad_pixel_coverage_3x3.f
rtl/qpc_pkg.sv
rtl/quad_pixel_coverage_3x3.sv
verif/quad_pixel_coverage_3x3_tb.sv
